// ----- src/cidt_pkg.sv -----
// Shared types, constants and address helper for the CAN identifier dispatch table.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package cidt_pkg;

    localparam int NUM_BUSES   = 3;
    localparam int TABLE_DEPTH = 16;
    localparam int NUM_TABLES  = NUM_BUSES * 2;
    localparam int MEM_DEPTH   = NUM_TABLES * TABLE_DEPTH;

    localparam int ID_W     = 29;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int BUS_W    = 2;

    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam int TBL_W  = $clog2(NUM_TABLES);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    localparam logic [BUS_W-1:0] BUS_UNKNOWN = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_BUS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic             we;
        logic [TBL_W-1:0] idx;
        logic [CNT_W-1:0] value;
    } t_cnt_upd;

    // Flat memory address of position idx in table tbl.
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [TBL_W-1:0] tbl,
                                                     input logic [CNT_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(tbl) * ADDR_W'(TABLE_DEPTH);
        return base + ADDR_W'(idx);
    endfunction

endpackage

// ----- src/cidt_entry_mem.sv -----
// Identifier/handle storage for all tables: one write port, one registered read port.
// Depends on cidt_pkg.
`timescale 1ns / 1ps

module cidt_entry_mem (
    input  logic              i_clk,
    input  cidt_pkg::t_mem_req i_req,
    output cidt_pkg::t_entry  o_rdata
);

    cidt_pkg::t_entry r_mem [cidt_pkg::MEM_DEPTH];
    cidt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/cidt_count_file.sv -----
// Per-table fill counts, cleared by reset.
// Depends on cidt_pkg.
`timescale 1ns / 1ps

module cidt_count_file (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [cidt_pkg::TBL_W-1:0]  i_rd_idx,
    input  cidt_pkg::t_cnt_upd          i_upd,
    output logic [cidt_pkg::CNT_W-1:0]  o_count
);

    logic [cidt_pkg::CNT_W-1:0] r_count [cidt_pkg::NUM_TABLES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cidt_pkg::NUM_TABLES; k++) begin
                r_count[k] <= '0;
            end
        end else if (i_upd.we) begin
            r_count[i_upd.idx] <= i_upd.value;
        end
    end

    assign o_count = r_count[i_rd_idx];

endmodule

// ----- src/cidt_seq.sv -----
// Request sequencer: binary search, match check and insertion shift over the entry memory.
// Depends on cidt_pkg; drives cidt_entry_mem and cidt_count_file.
`timescale 1ns / 1ps

module cidt_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [cidt_pkg::BUS_W-1:0]    i_bus,
    input  logic                          i_is_extended,
    input  logic [cidt_pkg::ID_W-1:0]     i_can_id,
    input  logic [cidt_pkg::HANDLE_W-1:0] i_device_handle,
    input  cidt_pkg::t_entry              i_rdata,
    input  logic [cidt_pkg::CNT_W-1:0]    i_count,
    output logic [cidt_pkg::TBL_W-1:0]    o_cnt_idx,
    output cidt_pkg::t_mem_req            o_mem_req,
    output cidt_pkg::t_cnt_upd            o_cnt_upd,
    output logic                          o_result_valid,
    output logic [cidt_pkg::STATUS_W-1:0] o_status,
    output logic [cidt_pkg::HANDLE_W-1:0] o_found_handle,
    output logic [cidt_pkg::SLOT_W-1:0]   o_slot
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_MCHK = 3'd3;
    localparam logic [2:0] S_SHRD = 3'd4;
    localparam logic [2:0] S_SHWR = 3'd5;

    localparam int CW = cidt_pkg::CNT_W;

    logic [2:0] r_state, n_state;
    logic       r_valid, n_valid;

    logic                          r_req, n_req;
    logic [cidt_pkg::ID_W-1:0]     r_key, n_key;
    logic [cidt_pkg::HANDLE_W-1:0] r_handle, n_handle;
    logic [cidt_pkg::TBL_W-1:0]    r_tbl, n_tbl;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [CW-1:0]                 r_lo, n_lo;
    logic [CW-1:0]                 r_hi, n_hi;
    logic [CW-1:0]                 r_mid, n_mid;
    logic [CW-1:0]                 r_i, n_i;
    logic [cidt_pkg::STATUS_W-1:0] r_status, n_status;
    logic [cidt_pkg::HANDLE_W-1:0] r_fh, n_fh;
    logic [cidt_pkg::SLOT_W-1:0]   r_slot, n_slot;

    logic                       bad_bus;
    logic [cidt_pkg::TBL_W-1:0] in_tbl;
    logic [CW-1:0]              mid;
    logic                       match;

    assign bad_bus = (i_bus == cidt_pkg::BUS_UNKNOWN) || (32'(i_bus) >= cidt_pkg::NUM_BUSES);
    assign in_tbl  = cidt_pkg::TBL_W'({i_bus, i_is_extended});
    assign mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign match   = (i_rdata.id == r_key);

    assign o_cnt_idx = in_tbl;

    always_comb begin
        n_state  = r_state;
        n_valid  = 1'b0;
        n_req    = r_req;
        n_key    = r_key;
        n_handle = r_handle;
        n_tbl    = r_tbl;
        n_cnt    = r_cnt;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_i      = r_i;
        n_status = r_status;
        n_fh     = r_fh;
        n_slot   = r_slot;

        o_mem_req       = '0;
        o_mem_req.raddr = cidt_pkg::entry_addr(r_tbl, r_lo);
        o_cnt_upd       = '0;
        o_cnt_upd.idx   = r_tbl;
        o_cnt_upd.value = r_cnt + CW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req    = i_req_type;
                    n_key    = i_can_id;
                    n_handle = i_device_handle;
                    n_tbl    = in_tbl;
                    n_cnt    = i_count;
                    n_lo     = '0;
                    n_hi     = i_count;
                    n_fh     = '0;
                    n_slot   = '0;
                    if (bad_bus) begin
                        n_valid  = 1'b1;
                        n_status = cidt_pkg::ST_BAD_BUS;
                    end else if (!i_req_type && (i_count >= CW'(cidt_pkg::TABLE_DEPTH))) begin
                        n_valid  = 1'b1;
                        n_status = cidt_pkg::ST_FULL;
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    o_mem_req.raddr = cidt_pkg::entry_addr(r_tbl, mid);
                    n_mid   = mid;
                    n_state = S_SCMP;
                end else if (r_lo < r_cnt) begin
                    // fetch the lower-bound entry for the equality check
                    n_state = S_MCHK;
                end else if (r_req) begin
                    n_valid  = 1'b1;
                    n_status = cidt_pkg::ST_MISS;
                    n_state  = S_IDLE;
                end else begin
                    n_i     = r_cnt;
                    n_state = S_SHRD;
                end
            end
            S_SCMP: begin
                if (i_rdata.id < r_key) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SRCH;
            end
            S_MCHK: begin
                if (match) begin
                    n_valid  = 1'b1;
                    n_status = r_req ? cidt_pkg::ST_HIT : cidt_pkg::ST_DUPLICATE;
                    n_fh     = i_rdata.handle;
                    n_slot   = cidt_pkg::SLOT_W'(r_lo);
                    n_state  = S_IDLE;
                end else if (r_req) begin
                    n_valid  = 1'b1;
                    n_status = cidt_pkg::ST_MISS;
                    n_state  = S_IDLE;
                end else begin
                    n_i     = r_cnt;
                    n_state = S_SHRD;
                end
            end
            S_SHRD: begin
                if (r_i > r_lo) begin
                    o_mem_req.raddr = cidt_pkg::entry_addr(r_tbl, r_i - CW'(1));
                    n_state = S_SHWR;
                end else begin
                    // drop the new entry into its slot and bump the count
                    o_mem_req.we           = 1'b1;
                    o_mem_req.waddr        = cidt_pkg::entry_addr(r_tbl, r_lo);
                    o_mem_req.wdata.id     = r_key;
                    o_mem_req.wdata.handle = r_handle;
                    o_cnt_upd.we           = 1'b1;
                    n_valid  = 1'b1;
                    n_status = cidt_pkg::ST_INSERTED;
                    n_slot   = cidt_pkg::SLOT_W'(r_lo);
                    n_state  = S_IDLE;
                end
            end
            S_SHWR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = cidt_pkg::entry_addr(r_tbl, r_i);
                o_mem_req.wdata = i_rdata;
                n_i     = r_i - CW'(1);
                n_state = S_SHRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_key    <= n_key;
        r_handle <= n_handle;
        r_tbl    <= n_tbl;
        r_cnt    <= n_cnt;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_i      <= n_i;
        r_status <= n_status;
        r_fh     <= n_fh;
        r_slot   <= n_slot;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_found_handle = r_fh;
    assign o_slot         = r_slot;

endmodule

// ----- src/can_id_dispatch_table_unit.sv -----
// Bad bus, or full table on insert: answered from idle. Lookup: a read and a compare per
// search step (ceil(log2(count + 1)) steps), then a match check when the lower bound lies
// inside the table; insert adds a read and a write per shifted entry plus the final write.
// One beat at a time: start is taken when busy is low, as the entry memory has one read port
// and one write port. Reset clears all table counts; entry storage is not cleared. Results
// strobe one cycle, no stall. Uses cidt_pkg, cidt_entry_mem/_count_file/_seq.
`timescale 1ns / 1ps

module can_id_dispatch_table_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [cidt_pkg::BUS_W-1:0]    i_bus,
    input  logic                          i_is_extended,
    input  logic [cidt_pkg::ID_W-1:0]     i_can_id,
    input  logic [cidt_pkg::HANDLE_W-1:0] i_device_handle,
    output logic                          o_result_valid,
    output logic [cidt_pkg::STATUS_W-1:0] o_status,
    output logic [cidt_pkg::HANDLE_W-1:0] o_found_handle,
    output logic [cidt_pkg::SLOT_W-1:0]   o_slot
);

    // Memory port bundle and count update travel between the sequencer and storage.
    cidt_pkg::t_mem_req            mem_req;
    cidt_pkg::t_entry              mem_rdata;
    cidt_pkg::t_cnt_upd            cnt_upd;
    logic [cidt_pkg::TBL_W-1:0]    cnt_idx;
    logic [cidt_pkg::CNT_W-1:0]    cnt_value;

    // Hold identifiers and handles of all bus/frame-type tables in one flat memory.
    cidt_entry_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Keep one fill count per table; entries at or above the count are never used.
    cidt_count_file u_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (cnt_idx),
        .i_upd    (cnt_upd),
        .o_count  (cnt_value)
    );

    // Search, check and shift-insert one beat at a time.
    cidt_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_bus           (i_bus),
        .i_is_extended   (i_is_extended),
        .i_can_id        (i_can_id),
        .i_device_handle (i_device_handle),
        .i_rdata         (mem_rdata),
        .i_count         (cnt_value),
        .o_cnt_idx       (cnt_idx),
        .o_mem_req       (mem_req),
        .o_cnt_upd       (cnt_upd),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_found_handle  (o_found_handle),
        .o_slot          (o_slot)
    );

endmodule

// ----- dv/tb.sv -----
// Self-checking bench for can_id_dispatch_table_unit: queued requests, a table predictor,
// and per-field comparison of every strobed reply. Depends on cidt_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT  = 2000;  // cycles with no beat and no reply before giving up
    localparam int TAIL_CYCLES = 60;    // longer than the worst-case latency
    localparam int RANDOM_REQS = 725;

    // One request beat plus the pacing the sender applies before it.
    typedef struct {
        logic                          req_type;
        logic [cidt_pkg::BUS_W-1:0]    bus;
        logic                          is_ext;
        logic [cidt_pkg::ID_W-1:0]     can_id;
        logic [cidt_pkg::HANDLE_W-1:0] handle;
        int                            gap;       // idle cycles before raising start
        bit                            drain;     // hold until every reply is back
    } t_id_request;

    typedef struct {
        logic [cidt_pkg::STATUS_W-1:0] status;
        logic [cidt_pkg::HANDLE_W-1:0] handle;
        logic [cidt_pkg::SLOT_W-1:0]   slot;
    } t_table_reply;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          start           = 1'b0;
    logic                          busy;
    logic                          i_req_type      = 1'b0;
    logic [cidt_pkg::BUS_W-1:0]    i_bus           = '0;
    logic                          i_is_extended   = 1'b0;
    logic [cidt_pkg::ID_W-1:0]     i_can_id        = '0;
    logic [cidt_pkg::HANDLE_W-1:0] i_device_handle = '0;
    logic                          o_result_valid;
    logic [cidt_pkg::STATUS_W-1:0] o_status;
    logic [cidt_pkg::HANDLE_W-1:0] o_found_handle;
    logic [cidt_pkg::SLOT_W-1:0]   o_slot;

    can_id_dispatch_table_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_bus          (i_bus),
        .i_is_extended  (i_is_extended),
        .i_can_id       (i_can_id),
        .i_device_handle(i_device_handle),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_found_handle (o_found_handle),
        .o_slot         (o_slot)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the sorted tables, one per bus and frame type.
    logic [cidt_pkg::ID_W-1:0]     shadow_id     [cidt_pkg::NUM_TABLES][cidt_pkg::TABLE_DEPTH];
    logic [cidt_pkg::HANDLE_W-1:0] shadow_handle [cidt_pkg::NUM_TABLES][cidt_pkg::TABLE_DEPTH];
    int                            shadow_count  [cidt_pkg::NUM_TABLES] = '{default: 0};

    t_id_request  pending_q[$];   // requests not yet offered to the block
    t_table_reply reply_q[$];     // replies owed by the block, oldest first
    // identifiers registered per table, for hits
    logic [cidt_pkg::ID_W-1:0] id_pool[cidt_pkg::NUM_TABLES][$];

    int n_total    = 0;
    int n_sent     = 0;
    int n_errors   = 0;
    int idle_count = 0;
    int seen_status[8] = '{default: 0};

    // Work out the reply for one accepted request and apply it to the shadow tables.
    function automatic t_table_reply resolve_request(t_id_request r);
        t_table_reply rep;
        int           t;
        int           cnt;
        int           lo;
        int           hi;
        int           mid;
        bit           match;
        rep.status = cidt_pkg::ST_BAD_BUS;
        rep.handle = '0;
        rep.slot   = '0;
        if (r.bus >= cidt_pkg::NUM_BUSES || r.bus == cidt_pkg::BUS_UNKNOWN) begin
            return rep;
        end
        t   = int'(r.bus) * 2 + int'(r.is_ext);
        cnt = shadow_count[t];
        // Lower bound: first slot whose identifier is not below the key.
        lo = 0;
        hi = cnt;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_id[t][mid] < r.can_id) lo = mid + 1;
            else hi = mid;
        end
        match = (lo < cnt) && (shadow_id[t][lo] == r.can_id);
        if (r.req_type) begin
            if (match) begin
                rep.status = cidt_pkg::ST_HIT;
                rep.handle = shadow_handle[t][lo];
                rep.slot   = cidt_pkg::SLOT_W'(lo);
            end else begin
                rep.status = cidt_pkg::ST_MISS;
            end
        end else if (cnt >= cidt_pkg::TABLE_DEPTH) begin
            // Full check comes ahead of the duplicate check.
            rep.status = cidt_pkg::ST_FULL;
        end else if (match) begin
            rep.status = cidt_pkg::ST_DUPLICATE;
            rep.handle = shadow_handle[t][lo];
            rep.slot   = cidt_pkg::SLOT_W'(lo);
        end else begin
            // Shift larger entries up one slot, then drop the new one into the hole.
            for (int i = cnt; i > lo; i--) begin
                shadow_id[t][i]     = shadow_id[t][i-1];
                shadow_handle[t][i] = shadow_handle[t][i-1];
            end
            shadow_id[t][lo]     = r.can_id;
            shadow_handle[t][lo] = r.handle;
            shadow_count[t]      = cnt + 1;
            rep.status = cidt_pkg::ST_INSERTED;
            rep.slot   = cidt_pkg::SLOT_W'(lo);
        end
        return rep;
    endfunction

    // Mostly back-to-back or short pauses, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_req(input logic req_type, input logic [cidt_pkg::BUS_W-1:0] bus,
                           input logic is_ext, input logic [cidt_pkg::ID_W-1:0] can_id,
                           input logic [cidt_pkg::HANDLE_W-1:0] handle, input int gap,
                           input bit drain);
        t_id_request r;
        r.req_type = req_type;
        r.bus      = bus;
        r.is_ext   = is_ext;
        r.can_id   = can_id;
        r.handle   = handle;
        r.gap      = gap;
        r.drain    = drain;
        pending_q.push_back(r);
        n_total++;
        if (!req_type && bus < cidt_pkg::NUM_BUSES && bus != cidt_pkg::BUS_UNKNOWN)
            id_pool[int'(bus) * 2 + int'(is_ext)].push_back(can_id);
    endtask

    // Fresh identifier: full 29-bit, 11-bit standard range, or a tight cluster
    // so that inserts land between existing entries.
    function automatic logic [cidt_pkg::ID_W-1:0] fresh_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return cidt_pkg::ID_W'($urandom);
        if (r < 70) return cidt_pkg::ID_W'($urandom_range(0, 2047));
        return cidt_pkg::ID_W'(32'h0100_0000 + $urandom_range(0, 63));
    endfunction

    // Driver: hold start until the beat is taken, then load the next request and
    // count off its gap. Exactly one nonblocking write of start per edge.
    t_id_request cur_req;
    bit          loaded   = 1'b0;
    int          gap_left = 0;

    always @(posedge i_clk) begin
        bit take;
        bit drive;
        if (!i_rst_n) begin
            start    <= 1'b0;
            loaded   = 1'b0;
            gap_left = 0;
        end else begin
            take  = start && !busy;
            drive = 1'b0;
            if (take) begin
                reply_q.push_back(resolve_request(cur_req));
                n_sent++;
                loaded = 1'b0;
            end
            if (!loaded && pending_q.size() > 0) begin
                cur_req  = pending_q.pop_front();
                gap_left = cur_req.gap;
                loaded   = 1'b1;
            end
            if (start && !take) begin
                drive = 1'b1;                       // block busy: hold the beat
            end else if (loaded) begin
                if (gap_left > 0) gap_left--;
                else if (cur_req.drain && reply_q.size() != 0) drive = 1'b0;
                else drive = 1'b1;
            end
            start <= drive;
            if (drive) begin
                i_req_type      <= cur_req.req_type;
                i_bus           <= cur_req.bus;
                i_is_extended   <= cur_req.is_ext;
                i_can_id        <= cur_req.can_id;
                i_device_handle <= cur_req.handle;
            end
        end
    end

    // Monitor: every strobed reply must match the oldest owed reply, field by field.
    t_table_reply want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (reply_q.size() == 0) begin
                $display("%0t: reply with nothing owed: status %0d handle %0d slot %0d",
                         $time, o_status, o_found_handle, o_slot);
                n_errors++;
            end else begin
                want = reply_q.pop_front();
                seen_status[want.status]++;
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    n_errors++;
                end
                if (o_found_handle !== want.handle) begin
                    $display("%0t: found_handle expected %0d actual %0d",
                             $time, want.handle, o_found_handle);
                    n_errors++;
                end
                if (o_slot !== want.slot) begin
                    $display("%0t: slot expected %0d actual %0d",
                             $time, want.slot, o_slot);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: drop the run if neither a beat nor a reply moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d of %0d sent, %0d replies owed",
                     $time, n_sent, n_total, reply_q.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        int                            t;
        int                            r;
        logic                          req_type;
        logic [cidt_pkg::BUS_W-1:0]    bus;
        logic                          is_ext;
        logic [cidt_pkg::ID_W-1:0]     can_id;
        bit                            burst;

        // Directed: empty lookup, identifier extremes, handle extremes, middle insert,
        // hits, duplicate, bad bus on both request types, table separation, and all
        // 29 bits compared in the standard table.
        add_req(1'b1, 2'd0, 1'b0, '0,      8'h00, 0, 1'b0);
        add_req(1'b0, 2'd0, 1'b0, '0,      8'h00, 0, 1'b0);
        add_req(1'b0, 2'd0, 1'b0, '1,      8'hFF, 0, 1'b0);
        add_req(1'b0, 2'd0, 1'b0, 29'h155, 8'hA5, 1, 1'b0);
        add_req(1'b1, 2'd0, 1'b0, '1,      8'h00, 0, 1'b0);
        add_req(1'b1, 2'd0, 1'b0, '0,      8'hFF, 2, 1'b0);
        add_req(1'b0, 2'd0, 1'b0, 29'h155, 8'h5A, 0, 1'b0);
        add_req(1'b1, 2'd0, 1'b0, 29'h156, 8'h00, 0, 1'b0);
        add_req(1'b0, cidt_pkg::BUS_UNKNOWN, 1'b0, 29'h7FF, 8'h11, 0, 1'b0);
        add_req(1'b1, cidt_pkg::BUS_UNKNOWN, 1'b1, '1,      8'hEE, 3, 1'b0);
        add_req(1'b0, 2'd2, 1'b1, '1,             8'h3C, 0, 1'b0);
        add_req(1'b0, 2'd2, 1'b1, 29'h1000_0000,  8'hC3, 0, 1'b0);
        add_req(1'b1, 2'd2, 1'b0, '1,             8'h00, 0, 1'b0);
        add_req(1'b1, 2'd2, 1'b1, 29'h1000_0000,  8'h00, 0, 1'b0);
        add_req(1'b0, 2'd1, 1'b0, 29'h0AAA_AAAA,  8'h96, 0, 1'b0);
        add_req(1'b1, 2'd1, 1'b0, 29'h0AAA_AAAA & 29'h7FF, 8'h00, 0, 1'b0);
        add_req(1'b1, 2'd1, 1'b0, 29'h0AAA_AAAA,  8'h00, 1, 1'b0);
        add_req(1'b0, 2'd1, 1'b1, 29'h0AAA_AAAA & 29'h7FF, 8'h69, 0, 1'b0);
        add_req(1'b1, 2'd1, 1'b1, 29'h0AAA_AAAA & 29'h7FF, 8'h00, 0, 1'b0);

        // Random: mostly well-formed register/lookup traffic aimed at the identifiers
        // already registered, with fresh identifiers, near misses and bad buses mixed in.
        // Tables fill as the run goes on, so full-table replies appear in the later part.
        burst = 1'b0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 5) bus = cidt_pkg::BUS_UNKNOWN;
            else bus = cidt_pkg::BUS_W'($urandom_range(0, cidt_pkg::NUM_BUSES - 1));
            is_ext   = 1'($urandom);
            req_type = ($urandom_range(0, 99) < 35) ? 1'b0 : 1'b1;
            t = int'(bus) * 2 + int'(is_ext);
            can_id = fresh_id();
            if (bus != cidt_pkg::BUS_UNKNOWN && id_pool[t].size() > 0) begin
                r = $urandom_range(0, 99);
                if (!req_type) begin
                    if (r < 25) can_id = id_pool[t][$urandom_range(0, id_pool[t].size() - 1)];
                end else if (r < 60) begin
                    can_id = id_pool[t][$urandom_range(0, id_pool[t].size() - 1)];
                end else if (r < 80) begin
                    can_id = id_pool[t][$urandom_range(0, id_pool[t].size() - 1)];
                    can_id = ($urandom_range(0, 1) == 0) ? can_id + 1'b1 : can_id - 1'b1;
                end
            end
            // Pause until the block has answered everything at the head of the run
            // and every 150 requests after that.
            add_req(req_type, bus, is_ext, can_id, cidt_pkg::HANDLE_W'($urandom),
                    burst ? 0 : pick_gap(), (n % 150 == 0));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every beat to be taken and every reply to come back, then let the
        // latency window pass so a stray reply still gets caught.
        while (n_sent < n_total || reply_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (reply_q.size() != 0) begin
            $display("%0t: %0d replies never arrived", $time, reply_q.size());
            n_errors++;
        end

        $display("Ran %0d requests: %0d inserted, %0d duplicate, %0d table full,",
                 n_total, seen_status[cidt_pkg::ST_INSERTED],
                 seen_status[cidt_pkg::ST_DUPLICATE], seen_status[cidt_pkg::ST_FULL]);
        $display("  %0d bad bus, %0d hit, %0d miss; %0d mismatches",
                 seen_status[cidt_pkg::ST_BAD_BUS], seen_status[cidt_pkg::ST_HIT],
                 seen_status[cidt_pkg::ST_MISS], n_errors);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
